// ===== rtl/core/epj_pkg.sv =====
// Shared types, constants and saturating Q16.16 helpers for the
// eigenvector projection unit. No dependencies.
package epj_pkg;

  localparam int unsigned DW = 32;          // datapath word width
  localparam int unsigned FB = 16;          // fraction bits
  localparam int unsigned PW = 2 * DW;      // full product width
  localparam int unsigned MW = DW + FB;     // shifted magnitude width
  localparam int unsigned GW = 18;          // gamma register width
  localparam int unsigned LW = 31;          // light speed register width
  localparam int unsigned NCOEF = 6;

  typedef logic signed [DW-1:0] word_t;

  localparam word_t MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(DW-1){1'b0}}};
  localparam word_t ONEQ = word_t'(1) <<< FB;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PROJ = 1'b1;

  localparam logic [1:0] PART_ION = 2'd0;
  localparam logic [1:0] PART_ELE = 2'd1;
  localparam logic [1:0] PART_FLD = 2'd2;
  localparam logic [1:0] PART_BAD = 2'd3;

  localparam logic CFG_GAMMA = 1'b0;
  localparam logic CFG_LIGHT = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [1:0]             part;
    logic [NCOEF-1:0][DW-1:0] d;
  } req_t;

  // per-species derived state
  typedef struct packed {
    word_t u1;
    word_t u2;
    word_t u3;
    word_t c;
    word_t h;
    word_t hs;
  } spc_t;

  function automatic word_t qadd(word_t a, word_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
    return s[DW-1:0];
  endfunction

  function automatic word_t qsub(word_t a, word_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
    return s[DW-1:0];
  endfunction

  function automatic word_t qabs(word_t x);
    if (!x[DW-1]) return x;
    if (x == MINV) return MAXV;
    return -x;
  endfunction

  // halve, rounding toward zero
  function automatic word_t qhalf(word_t x);
    word_t t;
    t = x + word_t'(x[DW-1]);
    return t >>> 1;
  endfunction

  function automatic logic [DW-1:0] mag(word_t x);
    return x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  // apply sign to a magnitude and saturate to the word range
  function automatic word_t sat_mag(logic neg, logic [MW-1:0] m);
    logic [MW-1:0] lim;
    lim = {{(MW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    if (neg) begin
      if (m > lim + 1'b1) return MINV;
      return word_t'({DW{1'b0}} - m[DW-1:0]);
    end
    if (m > lim) return MAXV;
    return word_t'(m[DW-1:0]);
  endfunction

endpackage

// ===== rtl/core/epj_div.sv =====
// Restoring divider, one quotient bit per cycle: sat((|n| << FB) / |d|), signed by the operand signs.
// Depends on epj_pkg.
module epj_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  epj_pkg::word_t n_i,
  input  epj_pkg::word_t d_i,
  output logic           done_o,
  output epj_pkg::word_t res_o
);

  localparam int unsigned STEPS = epj_pkg::MW;
  localparam int unsigned CW = $clog2(STEPS);
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic                        busy_q, done_q, neg_q;
  logic [CW-1:0]               cnt_q;
  logic [epj_pkg::MW-1:0]      num_q;
  logic [epj_pkg::DW-1:0]      rem_q, dm_q;
  logic [epj_pkg::DW:0]        rem_sh;
  logic                        ge;

  assign rem_sh = {rem_q, num_q[epj_pkg::MW-1]};
  assign ge     = rem_sh >= {1'b0, dm_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (d_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dm_q  <= epj_pkg::mag(d_i);
      if (d_i == '0) begin
        // divide by zero: saturate on the numerator's sign
        num_q <= '1;
        neg_q <= n_i[epj_pkg::DW-1];
      end else begin
        num_q <= {epj_pkg::mag(n_i), {epj_pkg::FB{1'b0}}};
        neg_q <= n_i[epj_pkg::DW-1] ^ d_i[epj_pkg::DW-1];
      end
    end else if (busy_q) begin
      rem_q <= ge ? epj_pkg::DW'(rem_sh - {1'b0, dm_q}) : rem_sh[epj_pkg::DW-1:0];
      num_q <= {num_q[epj_pkg::MW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign res_o  = epj_pkg::sat_mag(neg_q, num_q);

endmodule

// ===== rtl/core/epj_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle:
// floor(sqrt(x << FB)) for non-negative x. Depends on epj_pkg.
module epj_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  epj_pkg::word_t x_i,
  output logic           done_o,
  output epj_pkg::word_t res_o
);

  localparam int unsigned SQ = epj_pkg::MW / 2;
  localparam int unsigned RW = SQ + 3;
  localparam int unsigned CW = $clog2(SQ);
  localparam logic [CW-1:0] LAST = CW'(SQ - 1);

  logic                   busy_q, done_q;
  logic [CW-1:0]          cnt_q;
  logic [epj_pkg::MW-1:0] num_q;
  logic [RW-1:0]          rem_q, rem_sh, trial;
  logic [SQ-1:0]          root_q;
  logic                   ge;

  assign rem_sh = {rem_q[RW-3:0], num_q[epj_pkg::MW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= {x_i, {epj_pkg::FB{1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[epj_pkg::MW-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[SQ-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign res_o  = epj_pkg::word_t'({{(epj_pkg::DW-SQ){1'b0}}, root_q});

endmodule

// ===== rtl/core/epj_front.sv =====
// Input side: accepts requests, drops the invalid ones and
// queues the rest (two entries) for the sequencer. Depends on epj_pkg.
module epj_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  epj_pkg::req_t req_i,
  output logic          avail_o,
  output epj_pkg::req_t head_o,
  input  logic          take_i
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned AW = $clog2(DEPTH);

  epj_pkg::req_t   mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;
  logic            keep, wr_en, rd_en;

  always_comb begin
    if (req_i.op == epj_pkg::OP_PROJ) begin
      keep = req_i.part != epj_pkg::PART_BAD;
    end else begin
      keep = req_i.part == epj_pkg::PART_ION || req_i.part == epj_pkg::PART_ELE;
    end
  end

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign avail_o = cnt_q != '0;
  assign wr_en   = push_i && !full_o && keep;
  assign rd_en   = take_i && avail_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= req_i;
  end

endmodule

// ===== rtl/core/epj_back.sv =====
// Sequencer: runs load and projection requests over one shared multiplier,
// the divider and the square root unit, holds species state and the
// result register. Depends on epj_pkg, epj_div, epj_sqrt.
module epj_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     avail_i,
  input  epj_pkg::req_t            head_i,
  output logic                     take_o,
  input  logic [epj_pkg::GW-1:0]   gamma_i,
  input  logic [epj_pkg::LW-1:0]   light_i,
  input  logic                     pop_i,
  output logic                     empty_o,
  output logic [1:0]               out_part_o,
  output epj_pkg::word_t           q_o [epj_pkg::NCOEF]
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    K_LOAD,
    K_SPEC,
    K_FIELD
  } kind_e;

  // load steps
  localparam logic [3:0] LD_U1 = 4'd0,  LD_U2 = 4'd1,  LD_U3 = 4'd2,  LD_M1 = 4'd3;
  localparam logic [3:0] LD_M2 = 4'd4,  LD_M3 = 4'd5,  LD_UM = 4'd6,  LD_RU = 4'd7;
  localparam logic [3:0] LD_DE = 4'd8,  LD_PR = 4'd9,  LD_PS = 4'd10, LD_GP = 4'd11;
  localparam logic [3:0] LD_GS = 4'd12, LD_GD = 4'd13, LD_SQ = 4'd14, LD_HD = 4'd15;
  // species projection steps
  localparam logic [3:0] SP_UC = 4'd0,  SP_A0 = 4'd1,  SP_A1 = 4'd2,  SP_A4 = 4'd3;
  localparam logic [3:0] SP_S2 = 4'd4,  SP_S3 = 4'd5,  SP_E0 = 4'd6,  SP_E1 = 4'd7;
  localparam logic [3:0] SP_E2 = 4'd8,  SP_E3 = 4'd9,  SP_E4 = 4'd10, SP_END = 4'd11;
  // field projection steps
  localparam logic [3:0] FD_SUM = 4'd0, FD_M4 = 4'd1, FD_M5 = 4'd2, FD_END = 4'd3;

  state_e          st_q;
  logic [3:0]      pc_q;
  epj_pkg::req_t   cur_q;
  epj_pkg::spc_t   spc_q [2];
  epj_pkg::spc_t   wrk_q, row_new;
  kind_e           kind;
  logic            last_step, is_div, is_sqrt, unit_step, fire, mul_en, emit;

  epj_pkg::word_t  w [epj_pkg::NCOEF];
  epj_pkg::word_t  r_q [epj_pkg::NCOEF];
  epj_pkg::word_t  out_q [epj_pkg::NCOEF];
  epj_pkg::word_t  acc_q, tmp_q, tmp2_q, s_q, xa_q, xb_q, ya_q, yb_q;
  epj_pkg::word_t  mul_a, mul_b, mp, div_n, sqrt_x, unit_res, gam, lsp;
  epj_pkg::word_t  div_res, sqrt_res;
  logic [epj_pkg::PW-1:0] prod_q;
  logic            pneg_q, div_done, sqrt_done, div_start, sqrt_start;
  logic            ovalid_q;
  logic [1:0]      opart_q;

  for (genvar i = 0; i < epj_pkg::NCOEF; i++) begin : g_w
    assign w[i]   = epj_pkg::word_t'(cur_q.d[i]);
    assign q_o[i] = out_q[i];
  end

  assign gam = epj_pkg::word_t'({{(epj_pkg::DW-epj_pkg::GW){1'b0}}, gamma_i});
  assign lsp = epj_pkg::word_t'({{(epj_pkg::DW-epj_pkg::LW){1'b0}}, light_i});
  assign mp  = epj_pkg::sat_mag(pneg_q, prod_q[epj_pkg::PW-1:epj_pkg::FB]);

  always_comb begin
    if (cur_q.op == epj_pkg::OP_LOAD) kind = K_LOAD;
    else if (cur_q.part == epj_pkg::PART_FLD) kind = K_FIELD;
    else kind = K_SPEC;
  end

  // operand selection per step
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    is_div  = 1'b0;
    is_sqrt = 1'b0;
    div_n   = '0;
    sqrt_x  = tmp2_q;
    last_step = 1'b0;
    unique case (kind)
      K_LOAD: begin
        last_step = pc_q == LD_HD;
        unique case (pc_q)
          LD_U1: begin is_div = 1'b1; div_n = w[1]; end
          LD_U2: begin is_div = 1'b1; div_n = w[2]; end
          LD_U3: begin is_div = 1'b1; div_n = w[3]; end
          LD_M1: begin mul_a = wrk_q.u1; mul_b = wrk_q.u1; end
          LD_M2: begin mul_a = wrk_q.u2; mul_b = wrk_q.u2; end
          LD_M3: begin mul_a = wrk_q.u3; mul_b = wrk_q.u3; end
          LD_RU: begin mul_a = w[0]; mul_b = acc_q; end
          LD_PR: begin mul_a = xa_q; mul_b = tmp_q; end
          LD_GP: begin mul_a = gam; mul_b = tmp2_q; end
          LD_GD: begin is_div = 1'b1; div_n = tmp2_q; end
          LD_SQ: is_sqrt = 1'b1;
          LD_HD: begin is_div = 1'b1; div_n = tmp_q; end
          default: ;
        endcase
      end
      K_SPEC: begin
        last_step = pc_q == SP_END;
        unique case (pc_q)
          SP_UC: begin mul_a = wrk_q.u1; mul_b = wrk_q.c; end
          SP_A0: begin mul_a = xa_q; mul_b = w[0]; end
          SP_A1: begin mul_a = wrk_q.u1; mul_b = w[1]; end
          SP_A4: begin mul_a = xb_q; mul_b = w[4]; end
          SP_S2: begin mul_a = wrk_q.u2; mul_b = s_q; end
          SP_S3: begin mul_a = wrk_q.u3; mul_b = s_q; end
          SP_E0: begin mul_a = ya_q; mul_b = w[0]; end
          SP_E1: begin mul_a = wrk_q.hs; mul_b = w[1]; end
          SP_E2: begin mul_a = wrk_q.u2; mul_b = w[2]; end
          SP_E3: begin mul_a = wrk_q.u3; mul_b = w[3]; end
          SP_E4: begin mul_a = yb_q; mul_b = w[4]; end
          default: ;
        endcase
      end
      K_FIELD: begin
        last_step = pc_q == FD_END;
        unique case (pc_q)
          FD_M4: begin mul_a = lsp; mul_b = xa_q; end
          FD_M5: begin mul_a = lsp; mul_b = xb_q; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign unit_step  = is_div || is_sqrt;
  assign div_start  = st_q == S_EXEC && is_div;
  assign sqrt_start = st_q == S_EXEC && is_sqrt;
  assign mul_en     = st_q == S_EXEC;
  assign fire       = (st_q == S_EXEC && !unit_step) ||
                      (st_q == S_WAIT && (div_done || sqrt_done));
  assign emit       = st_q == S_EMIT && (!ovalid_q || pop_i);
  assign unit_res   = is_sqrt ? sqrt_res : div_res;
  assign take_o     = st_q == S_IDLE && avail_i;
  assign empty_o    = !ovalid_q;
  assign out_part_o = opart_q;

  always_comb begin
    row_new   = wrk_q;
    row_new.h = unit_res;
  end

  epj_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (w[0]),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  epj_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sqrt_x),
    .done_o  (sqrt_done),
    .res_o   (sqrt_res)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      pc_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (emit) ovalid_q <= 1'b1;
      else if (pop_i) ovalid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (avail_i) begin
            st_q <= S_EXEC;
            pc_q <= '0;
          end
        end
        S_EXEC, S_WAIT: begin
          if (st_q == S_EXEC && unit_step) begin
            st_q <= S_WAIT;
          end else if (fire) begin
            pc_q <= pc_q + 1'b1;
            if (last_step) st_q <= (kind == K_LOAD) ? S_IDLE : S_EMIT;
            else st_q <= S_EXEC;
          end
        end
        S_EMIT: begin
          if (emit) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      cur_q <= head_i;
      wrk_q <= spc_q[head_i.part[0]];
    end
    if (mul_en) begin
      prod_q <= epj_pkg::PW'(epj_pkg::mag(mul_a)) * epj_pkg::PW'(epj_pkg::mag(mul_b));
      pneg_q <= mul_a[epj_pkg::DW-1] ^ mul_b[epj_pkg::DW-1];
    end
    if (emit) begin
      out_q   <= r_q;
      opart_q <= cur_q.part;
    end
    if (fire) begin
      unique case (kind)
        K_LOAD: begin
          unique case (pc_q)
            LD_U1: wrk_q.u1 <= unit_res;
            LD_U2: wrk_q.u2 <= unit_res;
            LD_U3: wrk_q.u3 <= unit_res;
            LD_M2: acc_q <= mp;
            LD_M3: acc_q <= epj_pkg::qadd(acc_q, mp);
            LD_UM: acc_q <= epj_pkg::qadd(acc_q, mp);
            LD_RU: begin
              wrk_q.hs <= epj_pkg::qhalf(acc_q);
              xa_q     <= epj_pkg::qsub(gam, epj_pkg::ONEQ);
            end
            LD_DE: tmp_q  <= epj_pkg::qsub(w[4], epj_pkg::qhalf(mp));
            LD_PS: tmp2_q <= mp;                       // pressure
            LD_GP: tmp_q  <= epj_pkg::qadd(w[4], tmp2_q);
            LD_GS: tmp2_q <= mp;
            LD_GD: tmp2_q <= epj_pkg::qabs(unit_res);
            LD_SQ: wrk_q.c <= unit_res;
            LD_HD: spc_q[cur_q.part[0]] <= row_new;
            default: ;
          endcase
        end
        K_SPEC: begin
          unique case (pc_q)
            SP_UC: begin
              s_q  <= epj_pkg::qadd(w[0], w[1]);
              xa_q <= epj_pkg::qsub(wrk_q.u1, wrk_q.c);
              xb_q <= epj_pkg::qadd(wrk_q.u1, wrk_q.c);
            end
            SP_A0: begin
              tmp_q <= mp;                             // u1*c
              s_q   <= epj_pkg::qadd(s_q, w[4]);
            end
            SP_A1: begin
              acc_q <= mp;
              ya_q  <= epj_pkg::qsub(wrk_q.h, tmp_q);
              yb_q  <= epj_pkg::qadd(wrk_q.h, tmp_q);
            end
            SP_A4, SP_S2: acc_q <= epj_pkg::qadd(acc_q, mp);
            SP_S3: begin
              r_q[1] <= acc_q;
              r_q[2] <= epj_pkg::qadd(mp, w[2]);
            end
            SP_E0: r_q[3] <= epj_pkg::qadd(mp, w[3]);
            SP_E1: acc_q <= mp;
            SP_E2, SP_E3, SP_E4: acc_q <= epj_pkg::qadd(acc_q, mp);
            SP_END: begin
              r_q[0] <= s_q;
              r_q[4] <= epj_pkg::qadd(acc_q, mp);
              r_q[5] <= '0;
            end
            default: ;
          endcase
        end
        K_FIELD: begin
          unique case (pc_q)
            FD_SUM: begin
              r_q[0] <= w[2];
              r_q[1] <= epj_pkg::qadd(w[0], w[4]);
              r_q[2] <= epj_pkg::qadd(w[1], w[5]);
              r_q[3] <= w[3];
              xa_q   <= epj_pkg::qsub(w[5], w[1]);
              xb_q   <= epj_pkg::qsub(w[0], w[4]);
            end
            FD_M5:  r_q[4] <= mp;
            FD_END: r_q[5] <= mp;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/eigenvector_projection_two_fluid_unit.sv =====
// Top level of the two-fluid eigenvector projection unit: config registers,
// input queue and sequencer. Depends on epj_pkg, epj_front, epj_back.
//
// Requests enter through a two-entry queue and are worked one at a time by a
// sequencer around a single 32x32 multiplier (one product per cycle), a
// one-bit-per-cycle divider and a one-bit-per-cycle square root. A species
// load runs five divides and one square root. Loads and invalid requests
// produce no result. Projecting a species that was never loaded returns
// undefined values.
// Write gamma and light speed only while the unit is idle.
module eigenvector_projection_two_fluid_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        operation_i,
  input  logic [1:0]                  part_i,
  input  logic signed [31:0]          d0_i,
  input  logic signed [31:0]          d1_i,
  input  logic signed [31:0]          d2_i,
  input  logic signed [31:0]          d3_i,
  input  logic signed [31:0]          d4_i,
  input  logic signed [31:0]          d5_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [1:0]                  out_part_o,
  output logic signed [31:0]          q0_o,
  output logic signed [31:0]          q1_o,
  output logic signed [31:0]          q2_o,
  output logic signed [31:0]          q3_o,
  output logic signed [31:0]          q4_o,
  output logic signed [31:0]          q5_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [epj_pkg::LW-1:0]      cfg_data_i
);

  logic [epj_pkg::GW-1:0] gamma_q;
  logic [epj_pkg::LW-1:0] light_q;
  epj_pkg::req_t          req, head;
  logic                   avail, take;
  epj_pkg::word_t         q [epj_pkg::NCOEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= epj_pkg::GW'(109227);
      light_q <= epj_pkg::LW'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        epj_pkg::CFG_GAMMA: gamma_q <= cfg_data_i[epj_pkg::GW-1:0];
        epj_pkg::CFG_LIGHT: light_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    req.op   = operation_i;
    req.part = part_i;
    req.d[0] = d0_i;
    req.d[1] = d1_i;
    req.d[2] = d2_i;
    req.d[3] = d3_i;
    req.d[4] = d4_i;
    req.d[5] = d5_i;
  end

  epj_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .full_o  (full_o),
    .req_i   (req),
    .avail_o (avail),
    .head_o  (head),
    .take_i  (take)
  );

  epj_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (avail),
    .head_i     (head),
    .take_o     (take),
    .gamma_i    (gamma_q),
    .light_i    (light_q),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_part_o (out_part_o),
    .q_o        (q)
  );

  assign q0_o = q[0];
  assign q1_o = q[1];
  assign q2_o = q[2];
  assign q3_o = q[3];
  assign q4_o = q[4];
  assign q5_o = q[5];

endmodule

// ===== tb/sv/eigenvector_projection_two_fluid_unit_tb.sv =====
// Self-checking testbench for eigenvector_projection_two_fluid_unit: loads,
// species and field projections against a built-in fixed-point predictor.
// Depends on epj_pkg and the unit RTL.
`timescale 1ns / 1ps

module eigenvector_projection_two_fluid_unit_tb;

  typedef struct {
    logic           op;
    logic [1:0]     part;
    epj_pkg::word_t d [6];
  } column_t;

  typedef struct {
    logic [1:0]     part;
    epj_pkg::word_t q [6];
  } conserved_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic full_o;
  logic operation_i = epj_pkg::OP_LOAD;
  logic [1:0] part_i = epj_pkg::PART_ION;
  logic signed [31:0] d0_i = '0, d1_i = '0, d2_i = '0, d3_i = '0, d4_i = '0, d5_i = '0;
  logic empty_o;
  logic pop_i = 1'b0;
  logic [1:0] out_part_o;
  logic signed [31:0] q0_o, q1_o, q2_o, q3_o, q4_o, q5_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = epj_pkg::CFG_GAMMA;
  logic [epj_pkg::LW-1:0] cfg_data_i = '0;

  eigenvector_projection_two_fluid_unit dut (.*);

  column_t    pending [$];
  conserved_t expected [$];
  int         errors = 0;
  bit         calm = 1'b0;
  logic       req_taken = 1'b0;
  int         push_gap = 0;
  int         pop_gap = 0;

  // predictor state
  longint gamma_q = 109227;
  longint light_q = 65536;
  epj_pkg::word_t  vel [6];
  epj_pkg::word_t  snd [2];
  epj_pkg::word_t  enth [2];
  epj_pkg::word_t  hsq [2];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic epj_pkg::word_t clamp_word(longint v);
    if (v > longint'(epj_pkg::MAXV)) return epj_pkg::MAXV;
    if (v < longint'(epj_pkg::MINV)) return epj_pkg::MINV;
    return epj_pkg::word_t'(v);
  endfunction

  function automatic epj_pkg::word_t signed_mag(bit neg, logic [63:0] m);
    if (neg) return (m > 64'h8000_0000) ? epj_pkg::MINV : epj_pkg::word_t'(-longint'(m));
    return (m > 64'h7fff_ffff) ? epj_pkg::MAXV : epj_pkg::word_t'(m);
  endfunction

  function automatic logic [63:0] abs64(epj_pkg::word_t x);
    longint v;
    v = x;
    return v < 0 ? -v : v;
  endfunction

  function automatic epj_pkg::word_t fx_add(epj_pkg::word_t a, epj_pkg::word_t b);
    return clamp_word(longint'(a) + longint'(b));
  endfunction

  function automatic epj_pkg::word_t fx_sub(epj_pkg::word_t a, epj_pkg::word_t b);
    return clamp_word(longint'(a) - longint'(b));
  endfunction

  function automatic epj_pkg::word_t fx_mul(epj_pkg::word_t a, epj_pkg::word_t b);
    logic [63:0] p;
    p = (abs64(a) * abs64(b)) >> epj_pkg::FB;
    return signed_mag(a[31] != b[31], p);
  endfunction

  function automatic epj_pkg::word_t fx_div(epj_pkg::word_t n, epj_pkg::word_t d);
    logic [63:0] qt;
    if (d == 0) return n[31] ? epj_pkg::MINV : epj_pkg::MAXV;
    qt = (abs64(n) << epj_pkg::FB) / abs64(d);
    return signed_mag(n[31] != d[31], qt);
  endfunction

  function automatic epj_pkg::word_t fx_abs(epj_pkg::word_t x);
    return clamp_word(longint'(abs64(x)));
  endfunction

  function automatic epj_pkg::word_t fx_half(epj_pkg::word_t x);
    return epj_pkg::word_t'(longint'(x) / 2);
  endfunction

  function automatic epj_pkg::word_t fx_root(epj_pkg::word_t x);
    logic [63:0] n, r, t;
    n = abs64(x) << epj_pkg::FB;
    r = '0;
    for (int b = 24; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return signed_mag(1'b0, r);
  endfunction

  // Valid loads update species state; valid projections return 1 with their column.
  function automatic bit project_column(column_t c, output conserved_t r);
    epj_pkg::word_t u1, u2, u3, um2, press, cs, h, hs, uc, s;
    int p;
    r.part = c.part;
    foreach (r.q[i]) r.q[i] = '0;
    if (c.op == epj_pkg::OP_LOAD) begin
      if (c.part > epj_pkg::PART_ELE) return 1'b0;
      p = int'(c.part);
      u1 = fx_div(c.d[1], c.d[0]);
      u2 = fx_div(c.d[2], c.d[0]);
      u3 = fx_div(c.d[3], c.d[0]);
      um2 = fx_add(fx_add(fx_mul(u1, u1), fx_mul(u2, u2)), fx_mul(u3, u3));
      press = fx_mul(fx_sub(epj_pkg::word_t'(gamma_q), epj_pkg::ONEQ),
                     fx_sub(c.d[4], fx_half(fx_mul(c.d[0], um2))));
      vel[3*p] = u1;
      vel[3*p+1] = u2;
      vel[3*p+2] = u3;
      snd[p] = fx_root(fx_abs(fx_div(fx_mul(epj_pkg::word_t'(gamma_q), press), c.d[0])));
      enth[p] = fx_div(fx_add(c.d[4], press), c.d[0]);
      hsq[p] = fx_half(um2);
      return 1'b0;
    end
    if (c.part == epj_pkg::PART_BAD) return 1'b0;
    if (c.part == epj_pkg::PART_FLD) begin
      r.q[0] = c.d[2];
      r.q[1] = fx_add(c.d[0], c.d[4]);
      r.q[2] = fx_add(c.d[1], c.d[5]);
      r.q[3] = c.d[3];
      r.q[4] = fx_mul(epj_pkg::word_t'(light_q), fx_sub(c.d[5], c.d[1]));
      r.q[5] = fx_mul(epj_pkg::word_t'(light_q), fx_sub(c.d[0], c.d[4]));
      return 1'b1;
    end
    p = int'(c.part);
    u1 = vel[3*p];
    u2 = vel[3*p+1];
    u3 = vel[3*p+2];
    cs = snd[p];
    h = enth[p];
    hs = hsq[p];
    uc = fx_mul(u1, cs);
    s = fx_add(fx_add(c.d[0], c.d[1]), c.d[4]);
    r.q[0] = s;
    r.q[1] = fx_add(fx_add(fx_mul(fx_sub(u1, cs), c.d[0]), fx_mul(u1, c.d[1])),
                    fx_mul(fx_add(u1, cs), c.d[4]));
    r.q[2] = fx_add(fx_mul(u2, s), c.d[2]);
    r.q[3] = fx_add(fx_mul(u3, s), c.d[3]);
    r.q[4] = fx_add(fx_add(fx_add(fx_add(fx_mul(fx_sub(h, uc), c.d[0]), fx_mul(hs, c.d[1])),
                                  fx_mul(u2, c.d[2])), fx_mul(u3, c.d[3])),
                    fx_mul(fx_add(h, uc), c.d[4]));
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // request driver
  always @(negedge clk_i) begin
    column_t c;
    logic nxt_push;
    nxt_push = push_i && !req_taken;
    if (!nxt_push) begin
      if (push_gap > 0) begin
        push_gap--;
      end else if (pending.size() > 0) begin
        c = pending.pop_front();
        operation_i <= c.op;
        part_i <= c.part;
        d0_i <= c.d[0];
        d1_i <= c.d[1];
        d2_i <= c.d[2];
        d3_i <= c.d[3];
        d4_i <= c.d[4];
        d5_i <= c.d[5];
        nxt_push = 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) push_gap = $urandom_range(1, 15);
      end
    end
    push_i <= nxt_push;
  end

  // result drain with random stalls
  always @(negedge clk_i) begin
    if (pop_gap > 0) begin
      pop_gap--;
      pop_i <= 1'b0;
    end else begin
      pop_i <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) pop_gap = $urandom_range(1, 15);
    end
  end

  // monitor: accept requests into the predictor, check results
  always @(posedge clk_i) begin
    column_t c;
    conserved_t r, e;
    epj_pkg::word_t got [6];
    req_taken <= rst_ni && push_i && !full_o;
    if (rst_ni && push_i && !full_o) begin
      c.op = operation_i;
      c.part = part_i;
      c.d[0] = d0_i; c.d[1] = d1_i; c.d[2] = d2_i;
      c.d[3] = d3_i; c.d[4] = d4_i; c.d[5] = d5_i;
      if (project_column(c, r)) expected.push_back(r);
    end
    if (rst_ni && pop_i && !empty_o) begin
      if (expected.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        e = expected.pop_front();
        got[0] = q0_o; got[1] = q1_o; got[2] = q2_o;
        got[3] = q3_o; got[4] = q4_o; got[5] = q5_o;
        if (out_part_o !== e.part)
          report_mismatch($sformatf("out_part %0d exp %0d", out_part_o, e.part));
        foreach (got[i])
          if (got[i] !== e.q[i])
            report_mismatch($sformatf("part %0d q%0d %h exp %h", e.part, i, got[i], e.q[i]));
      end
    end
  end

  function automatic epj_pkg::word_t pick_word();
    int m;
    m = $urandom_range(0, 9);
    if (m < 6)
      return epj_pkg::word_t'(longint'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
    if (m < 8) return epj_pkg::word_t'($urandom);
    case ($urandom_range(0, 4))
      0: return epj_pkg::MAXV;
      1: return epj_pkg::MINV;
      2: return '0;
      3: return epj_pkg::ONEQ;
      default: return -epj_pkg::ONEQ;
    endcase
  endfunction

  task automatic queue_column(logic op, logic [1:0] part, epj_pkg::word_t a,
                              epj_pkg::word_t b, epj_pkg::word_t c, epj_pkg::word_t d,
                              epj_pkg::word_t e, epj_pkg::word_t f);
    column_t x;
    x.op = op;
    x.part = part;
    x.d[0] = a; x.d[1] = b; x.d[2] = c; x.d[3] = d; x.d[4] = e; x.d[5] = f;
    pending.push_back(x);
  endtask

  task automatic queue_random(int n);
    column_t x;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      foreach (x.d[j]) x.d[j] = pick_word();
      if (k < 8) begin
        x.op = epj_pkg::OP_LOAD;
        x.part = 2'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0)
          x.d[0] = epj_pkg::word_t'($urandom_range(32'h0000_4000, 32'h0008_0000));
      end else if (k < 11) begin
        x.op = epj_pkg::OP_LOAD;
        x.part = 2'($urandom_range(2, 3));
      end else if (k < 13) begin
        x.op = epj_pkg::OP_PROJ;
        x.part = epj_pkg::PART_BAD;
      end else if (k < 33) begin
        x.op = epj_pkg::OP_PROJ;
        x.part = epj_pkg::PART_FLD;
      end else begin
        x.op = epj_pkg::OP_PROJ;
        x.part = 2'($urandom_range(0, 1));
      end
      pending.push_back(x);
    end
  endtask

  // wait until all requests are through, then let queued loads finish
  task automatic drain();
    while (pending.size() > 0 || push_i || expected.size() > 0) @(negedge clk_i);
    repeat (1000) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, longint val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= epj_pkg::LW'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == epj_pkg::CFG_GAMMA) gamma_q = val;
    else light_q = val;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    // both species loaded before any species projection
    queue_column(epj_pkg::OP_LOAD, epj_pkg::PART_ION, epj_pkg::ONEQ, 2 * epj_pkg::ONEQ,
                 -epj_pkg::ONEQ, epj_pkg::ONEQ / 2, 10 * epj_pkg::ONEQ, 0);
    queue_column(epj_pkg::OP_LOAD, epj_pkg::PART_ELE, 2 * epj_pkg::ONEQ, epj_pkg::ONEQ,
                 epj_pkg::ONEQ, -epj_pkg::ONEQ, epj_pkg::ONEQ, 0);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_ION, epj_pkg::ONEQ, epj_pkg::ONEQ,
                 epj_pkg::ONEQ, epj_pkg::ONEQ, epj_pkg::ONEQ, 0);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_ELE, -epj_pkg::ONEQ, 2 * epj_pkg::ONEQ, 0,
                 epj_pkg::ONEQ, -epj_pkg::ONEQ, epj_pkg::MAXV);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_ION, epj_pkg::MAXV, epj_pkg::MAXV,
                 epj_pkg::MINV, epj_pkg::MINV, epj_pkg::MAXV, epj_pkg::MINV);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_ELE, epj_pkg::MINV, epj_pkg::MINV,
                 epj_pkg::MAXV, epj_pkg::MAXV, epj_pkg::MINV, epj_pkg::MAXV);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_FLD, epj_pkg::MAXV, epj_pkg::MINV,
                 epj_pkg::MAXV, epj_pkg::MINV, epj_pkg::MINV, epj_pkg::MAXV);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_FLD, epj_pkg::MINV, epj_pkg::MAXV, 0, -1,
                 epj_pkg::MAXV, epj_pkg::MINV);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_FLD, epj_pkg::ONEQ, 2 * epj_pkg::ONEQ,
                 3 * epj_pkg::ONEQ, 4 * epj_pkg::ONEQ, 5 * epj_pkg::ONEQ, 6 * epj_pkg::ONEQ);
    // ignored requests
    queue_column(epj_pkg::OP_LOAD, epj_pkg::PART_FLD, 0, epj_pkg::MAXV, epj_pkg::MINV,
                 0, 0, 0);
    queue_column(epj_pkg::OP_LOAD, epj_pkg::PART_BAD, -1, -1, -1, -1, -1, -1);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_BAD, epj_pkg::MAXV, epj_pkg::MAXV,
                 epj_pkg::MAXV, epj_pkg::MAXV, epj_pkg::MAXV, epj_pkg::MAXV);
    // zero density saturates the quotients
    queue_column(epj_pkg::OP_LOAD, epj_pkg::PART_ION, 0, epj_pkg::ONEQ, -epj_pkg::ONEQ, 0,
                 epj_pkg::ONEQ, 0);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_ION, epj_pkg::ONEQ, -epj_pkg::ONEQ,
                 epj_pkg::ONEQ, epj_pkg::ONEQ, epj_pkg::ONEQ, 0);
    // negative density and negative energy
    queue_column(epj_pkg::OP_LOAD, epj_pkg::PART_ELE, -epj_pkg::ONEQ, 3 * epj_pkg::ONEQ,
                 epj_pkg::ONEQ, 2 * epj_pkg::ONEQ, -5 * epj_pkg::ONEQ, 0);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_ELE, epj_pkg::ONEQ, epj_pkg::ONEQ,
                 -epj_pkg::ONEQ, 0, 2 * epj_pkg::ONEQ, 0);
    queue_column(epj_pkg::OP_LOAD, epj_pkg::PART_ION, epj_pkg::MAXV, epj_pkg::MINV,
                 epj_pkg::MAXV, epj_pkg::MINV, epj_pkg::MAXV, 0);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_ION, -epj_pkg::ONEQ, 0, epj_pkg::ONEQ,
                 epj_pkg::ONEQ, -epj_pkg::ONEQ, 0);
    queue_column(epj_pkg::OP_LOAD, epj_pkg::PART_ION, epj_pkg::MINV, epj_pkg::MAXV,
                 epj_pkg::MINV, epj_pkg::MAXV, epj_pkg::MINV, 0);
    queue_column(epj_pkg::OP_PROJ, epj_pkg::PART_ION, 0, epj_pkg::ONEQ, 0, 0, 0, 0);
    queue_random(380);
    drain();
    write_reg(epj_pkg::CFG_GAMMA, 65536);
    write_reg(epj_pkg::CFG_LIGHT, 0);
    queue_random(380);
    drain();
    write_reg(epj_pkg::CFG_GAMMA, 196608);
    write_reg(epj_pkg::CFG_LIGHT, 31'h7fff_ffff);
    queue_random(380);
    drain();
    write_reg(epj_pkg::CFG_GAMMA, $urandom_range(65536, 196608));
    write_reg(epj_pkg::CFG_LIGHT, $urandom_range(0, 32'h7fff_ffff));
    queue_random(380);
    drain();
    write_reg(epj_pkg::CFG_GAMMA, 109227);
    write_reg(epj_pkg::CFG_LIGHT, 65536);
    calm = 1'b1;
    queue_random(380);
    drain();
    if (errors == 0) begin
      $display("PASS eigenvector_projection_two_fluid_unit");
    end else begin
      $display("FAIL eigenvector_projection_two_fluid_unit");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL eigenvector_projection_two_fluid_unit");
    $finish;
  end

endmodule
